### sv/deq_pkg.sv
// Package with the shared constants, codes, types and ring arithmetic of the deque.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ALL   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              push_front;
    logic              push_back;
    logic              pop_front;
    logic              pop_back;
    logic              list_step;
    logic              res_valid;
    logic [STAT_W-1:0] res_status;
    logic              res_last;
    logic              res_from_ram;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/deq_datapath.sv
// Datapath of the deque: ring store, front pointer, count, list index and result register.
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire deq_pkg::dp_cmd_t              cmd_i,
  input  wire logic signed [deq_pkg::DATA_W-1:0] value_i,
  output deq_pkg::dp_stat_t                  stat_o,
  output logic                               strobe_o,
  output logic signed [deq_pkg::DATA_W-1:0]  element_o,
  output logic [deq_pkg::STAT_W-1:0]         status_o,
  output logic                               last_o
);

  import deq_pkg::*;

  logic [PTR_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic [PTR_W-1:0]  front_dec;
  logic              we, re;
  logic [PTR_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic              valid_q;
  logic [STAT_W-1:0] status_q;
  logic              last_q;
  logic              from_ram_q;

  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.list_last = (CNT_W'(idx_q) == count_q - 1'b1);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = ring_add(front_q, count_q);
    raddr   = ring_add(front_q, CNT_W'(idx_q));
    if (cmd_i.push_front) begin
      we      = 1'b1;
      waddr   = front_dec;
      front_d = front_dec;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.push_back) begin
      we      = 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_front) begin
      re      = 1'b1;
      raddr   = front_q;
      front_d = ring_add(front_q, CNT_W'(1));
      count_d = count_q - 1'b1;
    end
    if (cmd_i.pop_back) begin
      re      = 1'b1;
      raddr   = ring_add(front_q, count_q - 1'b1);
      count_d = count_q - 1'b1;
    end
    if (cmd_i.list_step) begin
      re    = 1'b1;
      idx_d = stat_o.list_last ? '0 : idx_q + 1'b1;
    end
  end

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      valid_q    <= 1'b0;
      status_q   <= ST_OK;
      last_q     <= 1'b0;
      from_ram_q <= 1'b0;
    end else begin
      front_q    <= front_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      valid_q    <= cmd_i.res_valid;
      status_q   <= cmd_i.res_status;
      last_q     <= cmd_i.res_last;
      from_ram_q <= cmd_i.res_from_ram;
    end
  end

  assign strobe_o  = valid_q;
  assign element_o = from_ram_q ? $signed(rdata) : '0;
  assign status_o  = status_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

### sv/deq_ctrl.sv
// Controller of the deque: decodes each request and sequences the read-out of all elements.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [deq_pkg::CMD_W-1:0] command_i,
  input  wire deq_pkg::dp_stat_t         stat_i,
  output deq_pkg::dp_cmd_t               cmd_o,
  output logic                           busy_o
);

  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign busy_o = (state_q == S_LIST);
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              cmd_o.res_valid = 1'b1;
              cmd_o.res_last  = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.res_status = ST_OK;
                cmd_o.push_front = (command_i == CMD_PUSH_FRONT);
                cmd_o.push_back  = (command_i == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              cmd_o.res_valid = 1'b1;
              cmd_o.res_last  = 1'b1;
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.res_status   = ST_OK;
                cmd_o.res_from_ram = 1'b1;
                cmd_o.pop_front    = (command_i == CMD_POP_FRONT);
                cmd_o.pop_back     = (command_i == CMD_POP_BACK);
              end
            end
            CMD_READ_ALL: begin
              cmd_o.res_valid = 1'b1;
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
                cmd_o.res_last   = 1'b1;
              end else begin
                cmd_o.res_status   = ST_OK;
                cmd_o.res_from_ram = 1'b1;
                cmd_o.list_step    = 1'b1;
                cmd_o.res_last     = stat_i.list_last;
                if (!stat_i.list_last) begin
                  state_d = S_LIST;
                end
              end
            end
            default: begin
              cmd_o = '0;
            end
          endcase
        end
      end
      S_LIST: begin
        cmd_o.res_valid    = 1'b1;
        cmd_o.res_status   = ST_OK;
        cmd_o.res_from_ram = 1'b1;
        cmd_o.list_step    = 1'b1;
        cmd_o.res_last     = stat_i.list_last;
        if (stat_i.list_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
//   Channel   Handshake               Fields
//   request   start_i high, busy_o low   command_i, value_i
//   result    strobe_o, one cycle        element_o, status_o, last_o
//
// Each result is registered and appears in the cycle after the request or read step that causes it.
// A push or pop leaves busy_o low, so a new request may follow at once.
// Read all reads the ring store once per element through the single read port and holds
// busy_o high after its request until the read step for the last held element.
// Reset clears the pointer, the count and the controller; the store needs no clearing.
// The receiver cannot stall: every result is taken in the cycle it is shown.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [deq_pkg::CMD_W-1:0]            command_i,
  input  wire logic signed [deq_pkg::DATA_W-1:0]    value_i,
  output logic                                      strobe_o,
  output logic signed [deq_pkg::DATA_W-1:0]         element_o,
  output logic [deq_pkg::STAT_W-1:0]                status_o,
  output logic                                      last_o
);

  import deq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .command_i(command_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  deq_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (value_i),
    .stat_o   (stat),
    .strobe_o (strobe_o),
    .element_o(element_o),
    .status_o (status_o),
    .last_o   (last_o)
  );

endmodule

`default_nettype wire

### sv/deq_checker.sv
// Port-level assertions for the deque and the bind that attaches them to the top level.
`timescale 1ns / 1ps
`default_nettype none

module deq_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start_i,
  input wire logic                                 busy_o,
  input wire logic [deq_pkg::CMD_W-1:0]            command_i,
  input wire logic                                 strobe_o,
  input wire logic signed [deq_pkg::DATA_W-1:0]    element_o,
  input wire logic [deq_pkg::STAT_W-1:0]           status_o,
  input wire logic                                 last_o
);

  import deq_pkg::*;

  a_valid_cmd_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i <= CMD_READ_ALL) |=> strobe_o)
    else $error("Accepted request produced no result.");

  a_busy_streams : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> strobe_o)
    else $error("Read-out step produced no result.");

  a_not_last_means_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy_o)
    else $error("Unfinished read-out while not busy.");

  a_fail_is_last_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o != ST_OK) |-> (last_o && element_o == '0))
    else $error("Failed request result is not a final zero result.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench that drives requests into the double-ended queue and checks every result.
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } reply_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CAP  = 400;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     strobe_o;
  logic signed [DATA_W-1:0] element_o;
  logic [STAT_W-1:0]        status_o;
  logic                     last_o;

  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int     front_slot;
  int     held_count;
  reply_t expected_replies [$];

  int     errors;
  int     requests_taken;
  int     replies_checked;
  int     full_refusals;
  int     empty_replies;
  int     longest_readout;
  int     idle_pct;
  bit     growing;
  longint cycles = 0;

  double_ended_queue dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .command_i (command_i),
    .value_i   (value_i),
    .strobe_o  (strobe_o),
    .element_o (element_o),
    .status_o  (status_o),
    .last_o    (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Works out the results of one accepted request and updates the shadow queue.
  task automatic model_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val);
    reply_t r;
    int     slot;
    r = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held_count == DEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
          growing = 1'b0;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            shadow_ring[front_slot] = val;
          end else begin
            shadow_ring[(front_slot + held_count) % DEPTH] = val;
          end
          held_count++;
          r.status = ST_OK;
        end
        expected_replies.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          empty_replies++;
          growing = 1'b1;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            r.element = shadow_ring[front_slot];
            front_slot = (front_slot + 1) % DEPTH;
          end else begin
            slot = (front_slot + held_count - 1) % DEPTH;
            r.element = shadow_ring[slot];
          end
          held_count--;
          r.status = ST_OK;
        end
        expected_replies.push_back(r);
      end
      CMD_READ_ALL: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          empty_replies++;
          expected_replies.push_back(r);
        end else begin
          for (int i = 0; i < held_count; i++) begin
            r.element = shadow_ring[(front_slot + i) % DEPTH];
            r.status  = ST_OK;
            r.last    = (i == held_count - 1);
            expected_replies.push_back(r);
          end
          if (held_count > longest_readout) begin
            longest_readout = held_count;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Presents one request, waits until it is taken, then maybe idles for a while.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic signed [DATA_W-1:0] val);
    start_i   = 1'b1;
    command_i = cmd;
    value_i   = val;
    do @(posedge clk_i); while (busy_o);
    model_request(cmd, val);
    requests_taken++;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i   = 1'b0;
      command_i = 3'($urandom);
      value_i   = $urandom;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_all_results();
    start_i = 1'b0;
    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    reply_t want;
    if (rst_ni && strobe_o) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual element %0d status %0d last %0d",
                 $time, element_o, status_o, last_o);
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (element_o !== want.element) begin
          errors++;
          $display("%0t: element mismatch, expected %0d, actual %0d",
                   $time, $signed(want.element), element_o);
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, last_o);
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_request(CMD_POP_FRONT, 32'sd5);
    send_request(CMD_POP_BACK, -32'sd5);
    send_request(CMD_READ_ALL, 32'sd0);
    wait_all_results();
  endtask

  task automatic test_push_pop_extremes();
    send_request(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_request(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_request(CMD_PUSH_FRONT, 32'sd0);
    send_request(CMD_PUSH_BACK, -32'sd1);
    send_request(CMD_PUSH_FRONT, 32'sd1);
    send_request(CMD_READ_ALL, 32'sd0);
    send_request(CMD_POP_FRONT, 32'sd0);
    send_request(CMD_POP_BACK, 32'sd0);
    send_request(CMD_READ_ALL, 32'sd0);
    send_request(CMD_POP_BACK, 32'sd0);
    send_request(CMD_POP_FRONT, 32'sd0);
    send_request(CMD_POP_FRONT, 32'sd0);
    send_request(CMD_POP_BACK, 32'sd0);
    wait_all_results();
  endtask

  task automatic test_ignored_codes();
    send_request(CMD_PUSH_BACK, $urandom);
    send_request(3'd5, $urandom);
    send_request(3'd6, $urandom);
    send_request(3'd7, $urandom);
    send_request(CMD_READ_ALL, $urandom);
    send_request(CMD_POP_FRONT, $urandom);
    wait_all_results();
  endtask

  // The queue is filled until a push is refused and then emptied until a pop finds it empty,
  // over and over, with a little noise mixed in.
  task automatic test_random_traffic(input int count, input int pct, input bit until_full);
    int               r;
    int               k;
    bit               paused;
    logic [CMD_W-1:0] cmd;
    idle_pct = pct;
    k = 0;
    paused = 1'b0;
    while (k < count || (until_full && full_refusals == 0 && k < RANDOM_CAP)) begin
      r = $urandom_range(99);
      if (r < 3) begin
        cmd = 3'($urandom_range(7, 5));
      end else begin
        if (r < 9) begin
          cmd = CMD_READ_ALL;
        end else if ((r < 87) == growing) begin
          cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        k++;
      end
      send_request(cmd, $urandom);
      if (!paused && k == count / 2) begin
        paused = 1'b1;
        wait_all_results();
      end
    end
    wait_all_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    command_i       = CMD_PUSH_FRONT;
    value_i         = '0;
    front_slot      = 0;
    held_count      = 0;
    errors          = 0;
    requests_taken  = 0;
    replies_checked = 0;
    full_refusals   = 0;
    empty_replies   = 0;
    longest_readout = 0;
    idle_pct        = 12;
    growing         = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_push_pop_extremes();
    test_ignored_codes();
    test_random_traffic(36, 12, 1'b0);
    test_random_traffic(36, 85, 1'b0);
    test_random_traffic(36, 0, 1'b1);

    $display("Run covered %0d requests and %0d checked results, read-outs up to %0d elements.",
             requests_taken, replies_checked, longest_readout);
    $display("It saw %0d refused pushes into a full queue and %0d empty statuses.",
             full_refusals, empty_replies);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
